FILE: hdl/lzwd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZW letter decoder package
// Shared constants, code classes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   localparam int CODE_W           = 12;
   localparam int LETTER_W         = 5;
   localparam int LEN_W            = 7;
   localparam int NFC_W            = 13;
   localparam int LETTER_COUNT     = 26;
   localparam int END_CODE         = 26;
   localparam int FIRST_FREE       = 27;
   localparam int ASCII_A          = 97;
   localparam int CODE_SPACE       = 4096;
   localparam int DICT_ENTRIES_DEF = 4096;
   localparam int MAX_LEN_DEF      = 64;

   // How the code just taken is to be handled.
   typedef enum logic [2:0] {
      CLS_END    = 3'd0,
      CLS_BAD    = 3'd1,
      CLS_FIRST  = 3'd2,
      CLS_NORMAL = 3'd3,
      CLS_KWK    = 3'd4
   } cls_type;

   typedef struct packed {
      logic load_code;
      logic decide;
      logic chase_rd;
      logic chase_step;
      logic push_letter;
      logic pop_rd;
      logic pop_load;
      logic tail_load;
      logic one_load;
      logic finish;
   } cmd_type;

   typedef struct packed {
      cls_type cls_now;
      cls_type cls_held;
      logic    cur_is_letter;
      logic    stack_empty;
      logic    out_free;
   } sts_type;

endpackage
`default_nettype wire

FILE: hdl/lzw_letter_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZW letter decoder
// Decodes a stream of LZW codes over the letters a..z into ASCII letter beats.
// ----------------------------------------------------------------------------
// Each request beat carries one code and is answered by one or more response
// beats, the final one marked with tlast. Codes 0..25 are the letters a..z,
// code 26 ends a message (one beat with the end flag in tuser, and the decoder
// returns to its initial dictionary), and codes from 27 up name dictionary
// entries built while decoding. An undefined code gives one beat with the bad
// flag and leaves the state untouched. One code at a time is worked on: the
// request side is ready only while the decoder idles. For a string the prefix
// chain is followed through the dictionary memory (registered read), and the
// letters then leave the letter stack (registered read). A full response
// register stalls the letter pop until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module lzw_letter_decoder #(
   parameter int DICT_ENTRIES   = lzwd_pkg::DICT_ENTRIES_DEF,
   parameter int MAX_STRING_LEN = lzwd_pkg::MAX_LEN_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [15:0] req_tdata,   // [11:0] code, [15:12] zero
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] letter
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser    // [0] end_of_message, [1] bad_code
);

   lzwd_pkg::cmd_type cmd;
   lzwd_pkg::sts_type sts;

   // The controller only sequences; all decoder state and the memories sit in the datapath.
   lzwd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lzwd_datapath #(
      .DICT_ENTRIES   (DICT_ENTRIES),
      .MAX_STRING_LEN (MAX_STRING_LEN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: hdl/lzwd_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZW letter decoder controller
// Sequences accept, classify, single-beat answers, prefix chase, letter pop and dictionary update.
// ----------------------------------------------------------------------------
module lzwd_controller (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  lzwd_pkg::sts_type sts,
   output lzwd_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE       = 9'b000000001,
      ST_DECIDE     = 9'b000000010,
      ST_ONE        = 9'b000000100,
      ST_CHASE      = 9'b000001000,
      ST_CHASE_WAIT = 9'b000010000,
      ST_POP_RD     = 9'b000100000,
      ST_POP_WR     = 9'b001000000,
      ST_TAIL       = 9'b010000000,
      ST_FINISH     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_code = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.cls_now == lzwd_pkg::CLS_NORMAL || sts.cls_now == lzwd_pkg::CLS_KWK) begin
               state_in = ST_CHASE;
            end else begin
               state_in = ST_ONE;
            end
         end
         ST_ONE: begin
            if (sts.out_free) begin
               cmd.one_load = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_CHASE: begin
            if (sts.cur_is_letter) begin
               cmd.push_letter = 1'b1;
               state_in        = ST_POP_RD;
            end else begin
               cmd.chase_rd = 1'b1;
               state_in     = ST_CHASE_WAIT;
            end
         end
         ST_CHASE_WAIT: begin
            cmd.chase_step = 1'b1;
            state_in       = ST_CHASE;
         end
         ST_POP_RD: begin
            if (sts.stack_empty) begin
               state_in = (sts.cls_held == lzwd_pkg::CLS_KWK) ? ST_TAIL : ST_FINISH;
            end else begin
               cmd.pop_rd = 1'b1;
               state_in   = ST_POP_WR;
            end
         end
         ST_POP_WR: begin
            if (sts.out_free) begin
               cmd.pop_load = 1'b1;
               state_in     = ST_POP_RD;
            end
         end
         ST_TAIL: begin
            if (sts.out_free) begin
               cmd.tail_load = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/lzwd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZW letter decoder datapath
// Dictionary memory, letter stack, decoder state and the result register.
// ----------------------------------------------------------------------------
module lzwd_datapath #(
   parameter int DICT_ENTRIES   = lzwd_pkg::DICT_ENTRIES_DEF,
   parameter int MAX_STRING_LEN = lzwd_pkg::MAX_LEN_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire  [15:0]       req_tdata,
   input  lzwd_pkg::cmd_type cmd,
   output lzwd_pkg::sts_type sts,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser
);

   localparam int DEPTH  = (DICT_ENTRIES < lzwd_pkg::CODE_SPACE) ?
                           DICT_ENTRIES : lzwd_pkg::CODE_SPACE;
   localparam int AW     = $clog2(DEPTH);
   localparam int SIW    = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_STRING_LEN + 1);
   localparam int CW     = lzwd_pkg::CODE_W;
   localparam int LW     = lzwd_pkg::LETTER_W;
   localparam int NW     = lzwd_pkg::LEN_W;
   localparam int FW     = lzwd_pkg::NFC_W;
   localparam int WORD_W = CW + 2 * LW + NW;

   // Entry word: prefix, tail letter, head letter, length (high to low).
   logic [WORD_W-1:0] dict_mem  [DEPTH];
   logic [LW-1:0]     stack_mem [MAX_STRING_LEN];

   logic [CW-1:0]     code_ff, code_in, prev_code_ff, prev_code_in, cur_ff, cur_in;
   lzwd_pkg::cls_type cls_ff, cls_in, cls_now;
   logic [LW-1:0]     prev_head_ff, prev_head_in, cap_head_ff, cap_head_in;
   logic [NW-1:0]     prev_len_ff, prev_len_in, cap_len_ff, cap_len_in;
   logic              have_ff, have_in, first_rd_ff, first_rd_in;
   logic [FW-1:0]     nf_ff, nf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_dec;
   logic [WORD_W-1:0] mem_rd_ff;
   logic [LW-1:0]     stk_rd_ff;
   logic              out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [7:0]        out_data_ff, out_data_in;
   logic [1:0]        out_user_ff, out_user_in;

   logic              code_is_letter, can_add, add_en, out_free, stk_we;
   logic [LW-1:0]     stk_wdata, add_tail;
   logic [CW-1:0]     rd_prefix;
   logic [LW-1:0]     rd_tail, rd_head;
   logic [NW-1:0]     rd_len;

   assign rd_prefix = mem_rd_ff[WORD_W-1 -: CW];
   assign rd_tail   = mem_rd_ff[2*LW+NW-1 -: LW];
   assign rd_head   = mem_rd_ff[LW+NW-1 -: LW];
   assign rd_len    = mem_rd_ff[NW-1:0];
   assign cnt_dec   = cnt_ff - 1'b1;
   assign out_free  = !out_valid_ff || rsp_tready;

   assign code_is_letter = code_ff < CW'(lzwd_pkg::LETTER_COUNT);
   assign can_add = (nf_ff < FW'(DEPTH)) && (prev_len_ff < NW'(MAX_STRING_LEN));

   always_comb begin
      if (code_ff == CW'(lzwd_pkg::END_CODE)) begin
         cls_now = lzwd_pkg::CLS_END;
      end else if (!have_ff) begin
         cls_now = code_is_letter ? lzwd_pkg::CLS_FIRST : lzwd_pkg::CLS_BAD;
      end else if (code_is_letter || (code_ff >= CW'(lzwd_pkg::FIRST_FREE) &&
                                      {1'b0, code_ff} < nf_ff)) begin
         cls_now = lzwd_pkg::CLS_NORMAL;
      end else if ({1'b0, code_ff} == nf_ff && can_add) begin
         cls_now = lzwd_pkg::CLS_KWK;
      end else begin
         cls_now = lzwd_pkg::CLS_BAD;
      end
   end

   assign sts.cls_now       = cls_now;
   assign sts.cls_held      = cls_ff;
   assign sts.cur_is_letter = cur_ff < CW'(lzwd_pkg::LETTER_COUNT);
   assign sts.stack_empty   = (cnt_ff == '0);
   assign sts.out_free      = out_free;

   assign stk_we    = cmd.push_letter || cmd.chase_step;
   assign stk_wdata = cmd.push_letter ? cur_ff[LW-1:0] : rd_tail;
   assign add_en    = cmd.finish && ((cls_ff == lzwd_pkg::CLS_NORMAL && can_add) ||
                                     cls_ff == lzwd_pkg::CLS_KWK);
   assign add_tail  = (cls_ff == lzwd_pkg::CLS_KWK) ? prev_head_ff : cap_head_ff;

   always_comb begin
      code_in      = code_ff;
      cls_in       = cls_ff;
      prev_code_in = prev_code_ff;
      prev_head_in = prev_head_ff;
      prev_len_in  = prev_len_ff;
      have_in      = have_ff;
      nf_in        = nf_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      first_rd_in  = first_rd_ff;
      cap_head_in  = cap_head_ff;
      cap_len_in   = cap_len_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;

      if (cmd.load_code) begin
         code_in = req_tdata[CW-1:0];
      end
      if (cmd.decide) begin
         cls_in      = cls_now;
         cur_in      = (cls_now == lzwd_pkg::CLS_KWK) ? prev_code_ff : code_ff;
         cnt_in      = '0;
         first_rd_in = 1'b1;
         cap_head_in = code_ff[LW-1:0];
         cap_len_in  = NW'(1);
      end
      if (cmd.push_letter) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.chase_step) begin
         cnt_in      = cnt_ff + 1'b1;
         cur_in      = rd_prefix;
         first_rd_in = 1'b0;
         if (first_rd_ff) begin
            cap_head_in = rd_head;
            cap_len_in  = rd_len;
         end
      end
      if (cmd.pop_rd) begin
         cnt_in = cnt_dec;
      end
      if (cmd.pop_load) begin
         out_valid_in = 1'b1;
         out_data_in  = 8'(lzwd_pkg::ASCII_A) + {3'b000, stk_rd_ff};
         out_last_in  = (cls_ff == lzwd_pkg::CLS_NORMAL) && (cnt_ff == '0);
         out_user_in  = 2'b00;
      end
      if (cmd.tail_load) begin
         out_valid_in = 1'b1;
         out_data_in  = 8'(lzwd_pkg::ASCII_A) + {3'b000, prev_head_ff};
         out_last_in  = 1'b1;
         out_user_in  = 2'b00;
      end
      if (cmd.one_load) begin
         out_valid_in = 1'b1;
         out_last_in  = 1'b1;
         case (cls_ff)
            lzwd_pkg::CLS_END: begin
               out_data_in = 8'h00;
               out_user_in = 2'b01;
            end
            lzwd_pkg::CLS_FIRST: begin
               out_data_in = 8'(lzwd_pkg::ASCII_A) + {3'b000, code_ff[LW-1:0]};
               out_user_in = 2'b00;
            end
            default: begin
               out_data_in = 8'h00;
               out_user_in = 2'b10;
            end
         endcase
      end
      if (cmd.finish) begin
         case (cls_ff)
            lzwd_pkg::CLS_END: begin
               have_in      = 1'b0;
               nf_in        = FW'(lzwd_pkg::FIRST_FREE);
               prev_code_in = '0;
               prev_head_in = '0;
               prev_len_in  = NW'(1);
            end
            lzwd_pkg::CLS_FIRST: begin
               have_in      = 1'b1;
               prev_code_in = code_ff;
               prev_head_in = code_ff[LW-1:0];
               prev_len_in  = NW'(1);
            end
            lzwd_pkg::CLS_NORMAL: begin
               prev_code_in = code_ff;
               prev_head_in = cap_head_ff;
               prev_len_in  = cap_len_ff;
            end
            lzwd_pkg::CLS_KWK: begin
               prev_code_in = code_ff;
               prev_len_in  = prev_len_ff + 1'b1;
            end
            default: begin
            end
         endcase
         if (add_en) begin
            nf_in = nf_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         nf_ff        <= FW'(lzwd_pkg::FIRST_FREE);
         prev_code_ff <= '0;
         prev_head_ff <= '0;
         prev_len_ff  <= NW'(1);
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         have_ff      <= have_in;
         nf_ff        <= nf_in;
         prev_code_ff <= prev_code_in;
         prev_head_ff <= prev_head_in;
         prev_len_ff  <= prev_len_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      cls_ff      <= cls_in;
      cur_ff      <= cur_in;
      first_rd_ff <= first_rd_in;
      cap_head_ff <= cap_head_in;
      cap_len_ff  <= cap_len_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   always_ff @(posedge clock) begin
      if (add_en) begin
         dict_mem[nf_ff[AW-1:0]] <= {prev_code_ff, add_tail, prev_head_ff,
                                     NW'(prev_len_ff + 1'b1)};
      end
      if (cmd.chase_rd) begin
         mem_rd_ff <= dict_mem[cur_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[cnt_ff[SIW-1:0]] <= stk_wdata;
      end
      if (cmd.pop_rd) begin
         stk_rd_ff <= stack_mem[cnt_dec[SIW-1:0]];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

`ifndef ASSERT_OFF
   a_nf_range: assert property (@(posedge clock) disable iff (reset)
      nf_ff >= FW'(lzwd_pkg::FIRST_FREE) && nf_ff <= FW'(DEPTH))
      else $error("next free code out of range");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_STRING_LEN))
      else $error("letter stack overflow");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_load || cmd.tail_load || cmd.one_load) |-> out_free)
      else $error("result loaded while previous beat still waits");
   a_add_once: assert property (@(posedge clock) disable iff (reset)
      add_en |=> nf_ff == $past(nf_ff) + 1'b1)
      else $error("dictionary add did not advance next free code");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_lzw_letter_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW letter decoder testbench
// Drives code beats with bursts and gaps, stalls the letter stream, and checks
// every response beat against an in-bench dictionary decoder.
// ----------------------------------------------------------------------------
// The decoder state is mirrored inside a scoreboard object. Each accepted code
// is decoded there into the letter beats it must produce. Those beats are
// queued and compared in order with the beats that leave the block. Most codes
// are chosen from the mirrored dictionary so that long strings, the
// code-equals-next-code case and the length cap are reached. The rest are noise
// codes, end codes and undefined codes.
// ----------------------------------------------------------------------------
module tb_lzw_letter_decoder;

   localparam int CODE_W       = lzwd_pkg::CODE_W;
   localparam int LETTER_W     = lzwd_pkg::LETTER_W;
   localparam int LETTER_COUNT = lzwd_pkg::LETTER_COUNT;
   localparam int END_CODE     = lzwd_pkg::END_CODE;
   localparam int FIRST_FREE   = lzwd_pkg::FIRST_FREE;
   localparam int ASCII_A      = lzwd_pkg::ASCII_A;
   localparam int CODE_SPACE   = lzwd_pkg::CODE_SPACE;
   localparam int CODE_LIMIT   = lzwd_pkg::DICT_ENTRIES_DEF < CODE_SPACE ?
                                 lzwd_pkg::DICT_ENTRIES_DEF : CODE_SPACE;
   localparam int STR_CAP      = lzwd_pkg::MAX_LEN_DEF;
   localparam int CYCLE_CAP    = 1000000;
   localparam int DRAIN_WAIT   = 300;

   // One expected response beat.
   typedef struct {
      logic [7:0] letter;
      bit         last;
      bit         eom;
      bit         bad;
   } letter_beat_type;

   // Mirror of the decoder: its dictionary, its registers and the beats owed.
   class letter_scoreboard;
      logic [CODE_W-1:0]   prefix_t [CODE_SPACE];
      logic [LETTER_W-1:0] tail_t   [CODE_SPACE];
      logic [LETTER_W-1:0] head_t   [CODE_SPACE];
      int unsigned         len_t    [CODE_SPACE];
      int unsigned         prev_code;
      bit                  have_prev;
      int unsigned         next_free;
      letter_beat_type     owed_q[$];
      int                  mismatches;

      function new();
         prev_code  = 0;
         have_prev  = 0;
         next_free  = FIRST_FREE;
         mismatches = 0;
      endfunction

      function int unsigned head_of(int unsigned c);
         return (c < LETTER_COUNT) ? c : head_t[c];
      endfunction

      function int unsigned len_of(int unsigned c);
         return (c < LETTER_COUNT) ? 1 : len_t[c];
      endfunction

      function bit can_add();
         return next_free < CODE_LIMIT && len_of(prev_code) + 1 <= STR_CAP;
      endfunction

      function void add_entry(int unsigned tail);
         prefix_t[next_free] = prev_code[CODE_W-1:0];
         tail_t[next_free]   = tail[LETTER_W-1:0];
         head_t[next_free]   = LETTER_W'(head_of(prev_code));
         len_t[next_free]    = len_of(prev_code) + 1;
         next_free++;
      endfunction

      function void owe(int unsigned letter, bit last, bit eom, bit bad);
         letter_beat_type b;
         b.letter = letter[7:0];
         b.last   = last;
         b.eom    = eom;
         b.bad    = bad;
         owed_q.push_back(b);
      endfunction

      // Queues the letters of code c, first letter first; last on the final one
      // only when the string ends the answer.
      function void owe_string(int unsigned c, bit final_flag);
         int unsigned stack[$];
         int unsigned n;
         n = 0;
         while (c >= FIRST_FREE && c < CODE_SPACE && n < STR_CAP - 1) begin
            stack.push_back(tail_t[c]);
            c = prefix_t[c];
            n++;
         end
         if (c < LETTER_COUNT && n < STR_CAP) stack.push_back(c);
         for (int i = stack.size() - 1; i >= 0; i--) begin
            owe(ASCII_A + stack[i] % LETTER_COUNT, final_flag && i == 0, 0, 0);
         end
      endfunction

      // Called for every accepted code beat.
      function void note_code(int unsigned code);
         int unsigned h;
         if (code == END_CODE) begin
            owe(0, 1, 1, 0);
            prev_code = 0;
            have_prev = 0;
            next_free = FIRST_FREE;
         end else if (!have_prev) begin
            if (code >= LETTER_COUNT) begin
               owe(0, 1, 0, 1);
            end else begin
               owe(ASCII_A + code, 1, 0, 0);
               prev_code = code;
               have_prev = 1;
            end
         end else if (code < LETTER_COUNT || (code >= FIRST_FREE && code < next_free)) begin
            owe_string(code, 1);
            if (can_add()) add_entry(head_of(code));
            prev_code = code;
         end else if (code == next_free && can_add()) begin
            // The code names the entry being built: previous string plus its
            // own first letter.
            h = head_of(prev_code);
            owe_string(prev_code, 0);
            owe(ASCII_A + h, 1, 0, 0);
            add_entry(h);
            prev_code = code;
         end else begin
            owe(0, 1, 0, 1);
         end
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_beat(logic [7:0] data, logic last, logic [1:0] user);
         letter_beat_type b;
         if (owed_q.size() == 0) begin
            report($sformatf("unexpected beat data=%h last=%b user=%b", data, last, user));
            return;
         end
         b = owed_q.pop_front();
         if (data !== b.letter || last !== b.last || user[0] !== b.eom || user[1] !== b.bad)
            report($sformatf("got data=%h last=%b eom=%b bad=%b, want %h %b %b %b",
                             data, last, user[0], user[1], b.letter, b.last, b.eom, b.bad));
      endtask

      // A code the decoder will accept as part of a well-formed message.
      function int unsigned pick_good();
         int unsigned r;
         if (!have_prev) return $urandom_range(0, LETTER_COUNT - 1);
         r = $urandom_range(0, 9);
         if (r < 3 || next_free == FIRST_FREE) return $urandom_range(0, LETTER_COUNT - 1);
         if (r < 7) return $urandom_range(FIRST_FREE, next_free - 1);
         if (r < 9 && can_add()) return next_free;
         return next_free - 1;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [11:0] code, [15:12] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] letter
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;   // [0] end_of_message, [1] bad_code

   letter_scoreboard sb;
   int  cycles;
   int  burst_left;
   bit  hold_request;
   int  hold_left;
   int  stall_mode;

   lzw_letter_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Cycle counter and timeout guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response side: checks each taken beat and drives a stall pattern of four kinds,
   // drawn anew at random, plus one long hold-off on request so that the block backs up
   // into its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tlast, rsp_tuser);
         if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
         if (hold_request && hold_left == 0) begin
            hold_left    <= 400;
            hold_request <= 1'b0;
            rsp_tready   <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= (hold_left == 1);
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 1) != 0);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Offers one code and waits until it is taken. Between bursts the valid line
   // drops for a random gap when that gap is not empty.
   task send_code(int unsigned code);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, code[CODE_W-1:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_code(code);
   endtask

   // Drops valid and waits for every owed beat; a closing wait on the clock lets
   // the next drive land in a fresh time step.
   task wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      int unsigned code;
      sb           = new();
      cycles       = 0;
      burst_left   = 0;
      hold_request = 1'b0;
      hold_left    = 0;
      stall_mode   = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: undefined first code, letter extremes, a dictionary code,
      // the code-equals-next-code case, codes past the dictionary, end codes.
      send_code(FIRST_FREE);
      send_code(CODE_SPACE - 1);
      send_code(0);
      send_code(LETTER_COUNT - 1);
      send_code(FIRST_FREE);
      send_code(sb.next_free);
      send_code(sb.next_free + 1);
      send_code(CODE_SPACE - 1);
      send_code(FIRST_FREE + 1);
      send_code(END_CODE);
      send_code(END_CODE);
      send_code(LETTER_COUNT - 1);
      send_code(sb.next_free);
      send_code(sb.next_free);
      send_code(12'h555);
      send_code(12'haaa);
      send_code(0);
      send_code(END_CODE);

      // Pause until every owed beat has gone out.
      wait_drained();

      // Growth chain: each code names the longest string so far, until the
      // length cap stops new entries; then a next-free code is refused.
      send_code(2);
      hold_request = 1'b1;
      for (int i = 0; i < 68; i++) begin
         send_code(sb.can_add() ? sb.next_free : sb.next_free - 1);
      end
      send_code(sb.next_free);
      send_code(END_CODE);

      // Random messages, mostly well formed, with noise and end codes.
      for (int i = 0; i < 80; i++) begin
         case ($urandom_range(0, 19))
            0, 1:    code = $urandom_range(0, CODE_SPACE - 1);
            2:       code = END_CODE;
            default: code = sb.pick_good();
         endcase
         send_code(code);
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: lzw_letter_decoder.f
hdl/lzwd_pkg.sv
hdl/lzwd_controller.sv
hdl/lzwd_datapath.sv
hdl/lzw_letter_decoder.sv
verif/tb_lzw_letter_decoder.sv
